FILE: hw/rtl/command_ring_fifo_defines.svh
// Assertion macros shared by the command ring FIFO checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef COMMAND_RING_FIFO_DEFINES_SVH
`define COMMAND_RING_FIFO_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("command_ring_fifo check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("command_ring_fifo check failed");

`endif

FILE: hw/rtl/crf_pkg.sv
// Shared types and constants for the command ring FIFO.
// No dependencies; imported by command_ring_fifo and crf_checker.
`default_nettype none

package crf_pkg;

    localparam int DEPTH     = 16;
    localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // Fixed field widths of the interface
    localparam int KIND_W     = 3;
    localparam int TYPE_W     = 16;
    localparam int DATA_W     = 32;
    localparam int OFFSET_W   = 4;
    localparam int FILL_W     = 5;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 5;

    localparam int SUM_W = ((PTR_W > OFFSET_W) ? PTR_W : OFFSET_W) + 1;

    localparam int S_TDATA_W = 56;  // 52 used bits padded to bytes
    localparam int S_TUSER_W = KIND_W;
    localparam int M_TDATA_W = 56;  // 54 used bits padded to bytes
    localparam int M_TUSER_W = 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH  = 3'd0,
        KIND_POP   = 3'd1,
        KIND_PEEK  = 3'd2,
        KIND_READ  = 3'd3,
        KIND_CLEAR = 3'd4
    } kind_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_OVERWRITE = 1'd0,
        REG_CAPACITY  = 1'd1
    } cfg_reg_t;

    typedef struct packed {
        kind_t                      kind;
        logic [TYPE_W-1:0]          cmd_type;
        logic signed [DATA_W-1:0]   cmd_data;
        logic [OFFSET_W-1:0]        offset;
    } in_word_t;

    typedef struct packed {
        logic                       hit;
        logic [TYPE_W-1:0]          out_type;
        logic signed [DATA_W-1:0]   out_data;
        logic [FILL_W-1:0]          fill_count;
        logic                       dropped;
    } out_word_t;

endpackage

`default_nettype wire

FILE: hw/rtl/command_ring_fifo.sv
// Command ring FIFO top level: input register, single-pass operation logic,
// result register. Depends on crf_pkg.
//
// A ring of DEPTH commands (16-bit type, 32-bit data) with a programmable
// capacity. Each input word carries one operation in s_axis_tuser (push,
// pop, peek, read at offset from the oldest entry, clear) and yields exactly
// one result word. Throughput is one word per clock while the result side
// is not stalled. The input register loads when a word is accepted, and the
// result register loads when that word is processed, from the pointer/count
// update logic and a read of the 16-entry flop store. A result waiting on
// m_axis_tready holds the word in the input register, so a new word is taken
// only while that register is empty. Config writes
// (cfg_wen/cfg_waddr/cfg_wdata) are expected only while the block is idle.
// Register 0 selects overwrite-oldest on a full push (else the push is
// dropped); register 1 sets capacity, saturated to 1..DEPTH, and any write
// to it empties the ring. No clearing pass is needed after reset.
`default_nettype none

module command_ring_fifo (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input words
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    // [15:0] cmd_type, [47:16] cmd_data, [51:48] offset, [55:52] zero
    input  wire logic [crf_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [2:0] kind
    input  wire logic [crf_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    // result words
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [15:0] out_type, [47:16] out_data, [52:48] fill_count, [53] dropped,
    // [55:54] zero
    output      logic [crf_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // [0] hit
    output      logic [crf_pkg::M_TUSER_W-1:0]   m_axis_tuser,
    // config write port
    input  wire logic                            cfg_wen,
    input  wire logic [crf_pkg::CFG_ADDR_W-1:0]  cfg_waddr,
    input  wire logic [crf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import crf_pkg::*;

    // ---- registers ----
    logic                     in_valid_reg;
    in_word_t                 in_word_reg;
    logic                     out_valid_reg, out_valid_next;
    out_word_t                out_word_reg, out_word_next;

    logic [TYPE_W-1:0]        type_store_reg [DEPTH];
    logic [DATA_W-1:0]        data_store_reg [DEPTH];

    logic [PTR_W-1:0]         head_reg, head_next;
    logic [PTR_W-1:0]         tail_reg, tail_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     overwrite_reg;
    logic [CNT_W-1:0]         cap_reg;       // effective capacity, 1..DEPTH

    // ---- handshake ----
    logic advance;          // in_word_reg is processed this cycle
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    in_word_t s_word;
    assign s_word.kind     = kind_t'(s_axis_tuser[KIND_W-1:0]);
    assign s_word.cmd_type = s_axis_tdata[TYPE_W-1:0];
    assign s_word.cmd_data = s_axis_tdata[TYPE_W+DATA_W-1:TYPE_W];
    assign s_word.offset   = s_axis_tdata[TYPE_W+DATA_W+OFFSET_W-1:TYPE_W+DATA_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_word_reg <= s_word;
        end
    end

    // ---- pointer arithmetic ----
    // wrap by one compare/subtract: sums stay below twice the capacity when offset < count
    logic [CNT_W-1:0]  head_inc_sum, tail_inc_sum;
    logic [PTR_W-1:0]  head_inc, tail_inc;
    logic [SUM_W-1:0]  slot_sum;
    logic [PTR_W-1:0]  slot;
    logic [PTR_W-1:0]  rd_addr;
    logic              full;
    logic              empty;
    logic              off_ok;

    assign head_inc_sum = CNT_W'(head_reg) + CNT_W'(1);
    assign tail_inc_sum = CNT_W'(tail_reg) + CNT_W'(1);
    assign head_inc     = (head_inc_sum == cap_reg) ? '0 : PTR_W'(head_inc_sum);
    assign tail_inc     = (tail_inc_sum == cap_reg) ? '0 : PTR_W'(tail_inc_sum);

    assign slot_sum = SUM_W'(head_reg) + SUM_W'(in_word_reg.offset);
    assign slot     = (slot_sum >= SUM_W'(cap_reg)) ? PTR_W'(slot_sum - SUM_W'(cap_reg))
                                                    : PTR_W'(slot_sum);

    assign full    = (count_reg == cap_reg);
    assign empty   = (count_reg == '0);
    assign off_ok  = SUM_W'(in_word_reg.offset) < SUM_W'(count_reg);
    assign rd_addr = (in_word_reg.kind == KIND_READ) ? slot : head_reg;

    // ---- operation logic ----
    logic store_wr;

    always_comb begin
        head_next              = head_reg;
        tail_next              = tail_reg;
        count_next             = count_reg;
        store_wr               = 1'b0;
        out_word_next.hit      = 1'b0;
        out_word_next.dropped  = 1'b0;

        unique case (in_word_reg.kind) inside
            KIND_PUSH: begin
                if (full && !overwrite_reg) begin
                    out_word_next.dropped = 1'b1;
                end else begin
                    store_wr  = 1'b1;
                    tail_next = tail_inc;
                    if (full) begin
                        head_next = head_inc;     // oldest entry overwritten
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            KIND_POP, KIND_PEEK: begin
                if (!empty) begin
                    out_word_next.hit = 1'b1;
                    if (in_word_reg.kind == KIND_POP) begin
                        head_next  = head_inc;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            KIND_READ: begin
                out_word_next.hit = off_ok;
            end
            KIND_CLEAR: begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            default: begin
                // unused kinds: miss, no state change
            end
        endcase

        out_word_next.out_type   = out_word_next.hit ? type_store_reg[rd_addr] : '0;
        out_word_next.out_data   = out_word_next.hit ? data_store_reg[rd_addr] : '0;
        out_word_next.fill_count = FILL_W'(count_next);
    end

    // ---- config decode ----
    logic [CNT_W-1:0] cap_wr;

    always_comb begin
        if (cfg_wdata == '0) begin
            cap_wr = CNT_W'(1);
        end else if (32'(cfg_wdata) > 32'(DEPTH)) begin
            cap_wr = CNT_W'(DEPTH);
        end else begin
            cap_wr = CNT_W'(cfg_wdata);
        end
    end

    // ---- state registers ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            overwrite_reg <= 1'b0;
            cap_reg       <= CNT_W'(DEPTH);
        end else if (cfg_wen) begin
            unique case (cfg_reg_t'(cfg_waddr))
                REG_OVERWRITE: begin
                    overwrite_reg <= cfg_wdata[0];
                end
                REG_CAPACITY: begin
                    cap_reg   <= cap_wr;
                    head_reg  <= '0;             // new ring starts empty
                    tail_reg  <= '0;
                    count_reg <= '0;
                end
                default: begin
                end
            endcase
        end else if (advance) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // command store, flop array, written at the tail slot only
    always_ff @(posedge aclk) begin
        if (advance && store_wr) begin
            type_store_reg[tail_reg] <= in_word_reg.cmd_type;
            data_store_reg[tail_reg] <= in_word_reg.cmd_data;
        end
    end

    // ---- result register ----
    always_comb begin
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_word_reg <= out_word_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = M_TUSER_W'(out_word_reg.hit);
    assign m_axis_tdata  = M_TDATA_W'({out_word_reg.dropped,
                                       out_word_reg.fill_count,
                                       out_word_reg.out_data,
                                       out_word_reg.out_type});

endmodule

`default_nettype wire

FILE: hw/rtl/crf_checker.sv
// Port-level checker for command_ring_fifo, attached by bind.
// Depends on crf_pkg and command_ring_fifo_defines.svh.
`default_nettype none

`include "command_ring_fifo_defines.svh"

module crf_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_axis_tvalid,
    input  wire logic                            s_axis_tready,
    input  wire logic [crf_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic [crf_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    input  wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic [crf_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  wire logic [crf_pkg::M_TUSER_W-1:0]   m_axis_tuser,
    input  wire logic                            cfg_wen,
    input  wire logic [crf_pkg::CFG_ADDR_W-1:0]  cfg_waddr,
    input  wire logic [crf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import crf_pkg::*;

    logic [FILL_W-1:0] fill;
    logic              dropped;
    logic              hit;

    assign fill    = m_axis_tdata[TYPE_W+DATA_W+FILL_W-1:TYPE_W+DATA_W];
    assign dropped = m_axis_tdata[TYPE_W+DATA_W+FILL_W];
    assign hit     = m_axis_tuser[0];

    // stalled result word holds
    `CRF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    // a miss returns zero type and data
    `CRF_ASSERT_NOW(a_miss_zero, aclk, aresetn, m_axis_tvalid && !hit, m_axis_tdata[TYPE_W+DATA_W-1:0] == '0)
    // a dropped push never returns a command
    `CRF_ASSERT_NOW(a_drop_no_hit, aclk, aresetn, m_axis_tvalid && dropped, !hit)
    // fill count never exceeds the built depth
    `CRF_ASSERT_NOW(a_fill_range, aclk, aresetn, m_axis_tvalid, 32'(fill) <= 32'(DEPTH))

endmodule

bind command_ring_fifo crf_checker u_crf_checker (.*);

`default_nettype wire

FILE: test/command_ring_fifo_tb.sv
// Self-checking bench for command_ring_fifo: directed and random command streams
// with random stalls on both sides. Depends on crf_pkg and the command_ring_fifo RTL.
`timescale 1ns / 100ps

module command_ring_fifo_tb;
    import crf_pkg::*;

    // kinds with no operation behind them; the block must answer with a plain miss
    localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

    localparam int  RANDOM_PHASES    = 6;
    localparam int  WORDS_PER_PHASE  = 80;
    localparam int  STALL_WORDS      = 40;
    localparam int  STALL_CYCLES     = 80;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [S_TDATA_W-1:0]     s_axis_tdata;   // [15:0] cmd_type, [47:16] cmd_data, [51:48] offset
    logic [S_TUSER_W-1:0]     s_axis_tuser;   // [2:0] kind
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [M_TDATA_W-1:0]     m_axis_tdata;   // [15:0] type, [47:16] data, [52:48] fill, [53] dropped
    logic [M_TUSER_W-1:0]     m_axis_tuser;   // [0] hit
    logic                     cfg_wen;
    logic [CFG_ADDR_W-1:0]    cfg_waddr;
    logic [CFG_DATA_W-1:0]    cfg_wdata;

    command_ring_fifo u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wen       (cfg_wen),
        .cfg_waddr     (cfg_waddr),
        .cfg_wdata     (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Ring mirror: our own copy of the stored commands, pointers and regs
    // ------------------------------------------------------------------
    logic [TYPE_W-1:0]  ring_type [DEPTH];
    logic [DATA_W-1:0]  ring_data [DEPTH];
    int unsigned        oldest;       // slot of the oldest command
    int unsigned        next_slot;    // slot the next push lands in
    int unsigned        stored;       // commands held
    bit                 ow_mode;      // overwrite-oldest on a full push
    logic [4:0]         cap_reg;      // raw capacity as written

    out_word_t          due_results[$];   // results owed by the block, oldest first

    // scoreboard / coverage tallies
    int unsigned        words_sent;
    int unsigned        words_checked;
    int unsigned        hit_count;
    int unsigned        drop_count;
    int unsigned        overwrite_count;
    int unsigned        reg_writes;
    int unsigned        mismatch_count;

    // stall knobs, percent of cycles the side sits idle
    int unsigned        src_idle_pct;
    int unsigned        sink_idle_pct;
    int unsigned        sink_hold;        // cycles of forced hold-off still to go

    // capacity 0 behaves as 1, anything past the built depth as the depth
    function automatic int unsigned ring_limit();
        if (cap_reg == 0) return 1;
        if (cap_reg > DEPTH) return DEPTH;
        return cap_reg;
    endfunction

    function automatic int unsigned ring_step(int unsigned p, int unsigned n);
        int unsigned s;
        s = p + n;
        while (s >= ring_limit()) s -= ring_limit();
        return s;
    endfunction

    function automatic void ring_flush();
        oldest    = 0;
        next_slot = 0;
        stored    = 0;
    endfunction

    // Apply one command to the mirror and return the result it owes.
    function automatic out_word_t ring_apply(logic [KIND_W-1:0] op, logic [TYPE_W-1:0] ctype,
                                             logic [DATA_W-1:0] cdata,
                                             logic [OFFSET_W-1:0] off);
        out_word_t   r;
        int unsigned lim;
        int unsigned slot;
        bit          full;
        r   = '0;
        lim = ring_limit();
        if (oldest >= lim) oldest = 0;
        if (next_slot >= lim) next_slot = 0;
        if (stored > lim) stored = lim;
        case (op)
            KIND_PUSH: begin
                full = (stored == lim);
                if (full && !ow_mode) begin
                    r.dropped = 1'b1;
                end else begin
                    ring_type[next_slot] = ctype;
                    ring_data[next_slot] = cdata;
                    next_slot = ring_step(next_slot, 1);
                    if (full) begin
                        // oldest command is lost, count holds
                        oldest = ring_step(oldest, 1);
                        overwrite_count++;
                    end else begin
                        stored++;
                    end
                end
            end
            KIND_POP, KIND_PEEK: begin
                if (stored != 0) begin
                    r.hit      = 1'b1;
                    r.out_type = ring_type[oldest];
                    r.out_data = ring_data[oldest];
                    if (op == KIND_POP) begin
                        oldest = ring_step(oldest, 1);
                        stored--;
                    end
                end
            end
            KIND_READ: begin
                if (off < stored) begin
                    slot       = ring_step(oldest, off);
                    r.hit      = 1'b1;
                    r.out_type = ring_type[slot];
                    r.out_data = ring_data[slot];
                end
            end
            KIND_CLEAR: ring_flush();
            default: ;
        endcase
        r.fill_count = stored[FILL_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driving side
    // ------------------------------------------------------------------

    // Offer one command word, with random gaps ahead of it; predict on accept.
    task automatic send_word(input logic [KIND_W-1:0] op, input logic [TYPE_W-1:0] ctype,
                             input logic [DATA_W-1:0] cdata, input logic [OFFSET_W-1:0] off);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, off, cdata, ctype};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        due_results.push_back(ring_apply(op, ctype, cdata, off));
        words_sent++;
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic drain_ring_traffic();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_results.size() != 0) @(posedge aclk);
    endtask

    // Register write; only called with the ring idle.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_waddr <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        reg_writes++;
        if (idx == REG_OVERWRITE) begin
            ow_mode = value[0];
        end else begin
            // a capacity write always empties the ring
            cap_reg = value;
            ring_flush();
        end
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result side: accept, compare against the oldest owed result, stall
    // ------------------------------------------------------------------
    task automatic log_mismatch(input string why);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t ns: %s", $time, why);
    endtask

    task automatic check_result();
        out_word_t got;
        out_word_t want;
        got.hit        = m_axis_tuser[0];
        got.out_type   = m_axis_tdata[15:0];
        got.out_data   = m_axis_tdata[47:16];
        got.fill_count = m_axis_tdata[52:48];
        got.dropped    = m_axis_tdata[53];
        words_checked++;
        if (got.hit === 1'b1) hit_count++;
        if (got.dropped === 1'b1) drop_count++;
        if (due_results.size() == 0) begin
            log_mismatch($sformatf("result word with nothing owed: hit=%0b type=%h data=%h fill=%0d drop=%0b",
                                   got.hit, got.out_type, got.out_data, got.fill_count, got.dropped));
        end else begin
            want = due_results.pop_front();
            if (got !== want)
                log_mismatch($sformatf({"result mismatch: exp hit=%0b type=%h data=%h fill=%0d drop=%0b",
                                        " / got hit=%0b type=%h data=%h fill=%0d drop=%0b"},
                                       want.hit, want.out_type, want.out_data, want.fill_count,
                                       want.dropped, got.hit, got.out_type, got.out_data,
                                       got.fill_count, got.dropped));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) check_result();
        if (sink_hold > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: discard on full, capacity 16. Empty misses, field
    // extremes, every operation, out-of-range reads, unused kinds, clear.
    task automatic test_basic_ops();
        send_word(KIND_POP,  '0, '0, '0);
        send_word(KIND_PEEK, '0, '0, '0);
        send_word(KIND_READ, '0, '0, 4'd0);
        send_word(KIND_PUSH, 16'hFFFF, 32'h7FFF_FFFF, '0);
        send_word(KIND_PUSH, 16'h0000, 32'h8000_0000, 4'hF);
        send_word(KIND_PUSH, 16'hA5A5, 32'hFFFF_FFFF, '0);
        send_word(KIND_PUSH, 16'h5A5A, 32'h0000_0000, '0);
        send_word(KIND_PEEK, '0, '0, '0);
        send_word(KIND_READ, '0, '0, 4'd3);
        send_word(KIND_READ, '0, '0, 4'd4);      // one past the last entry
        send_word(KIND_READ, 16'hFFFF, 32'hFFFF_FFFF, 4'hF);
        send_word(KIND_POP,  '0, '0, '0);
        for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
            send_word(k[KIND_W-1:0], 16'h1234, 32'h5678_9ABC, 4'd1);
        send_word(KIND_CLEAR, '0, '0, '0);
        send_word(KIND_POP,   '0, '0, '0);       // ring emptied by clear
    endtask

    // Capacity 1 in both full modes, capacity 0 read as 1, then 31 saturating.
    task automatic test_capacity_limits();
        drain_ring_traffic();
        write_reg(REG_CAPACITY, 5'd1);
        send_word(KIND_PUSH, 16'h0001, 32'h0000_0011, '0);
        send_word(KIND_PUSH, 16'h0002, 32'h0000_0022, '0);   // full, discarded
        drain_ring_traffic();
        write_reg(REG_OVERWRITE, 5'b11111);
        send_word(KIND_PUSH, 16'h0003, 32'h0000_0033, '0);   // full, replaces oldest
        send_word(KIND_PEEK, '0, '0, '0);
        send_word(KIND_READ, '0, '0, 4'd0);
        drain_ring_traffic();
        write_reg(REG_CAPACITY, 5'd0);
        send_word(KIND_PUSH, 16'h0004, 32'h0000_0044, '0);
        send_word(KIND_PUSH, 16'h0005, 32'h0000_0055, '0);
        send_word(KIND_POP,  '0, '0, '0);
        drain_ring_traffic();
        write_reg(REG_CAPACITY, 5'd31);
        write_reg(REG_OVERWRITE, 5'b11110);
    endtask

    // Random streams over several register settings. Push-heavy and
    // pop-heavy bursts alternate so the ring swings between full and empty.
    task automatic test_random_mix();
        logic [4:0]          cap_set [RANDOM_PHASES] = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd0, 5'd9};
        bit                  ow_set  [RANDOM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        logic [3:0]          junk;
        logic [KIND_W-1:0]   op;
        logic [TYPE_W-1:0]   ctype;
        logic [DATA_W-1:0]   cdata;
        logic [OFFSET_W-1:0] off;
        int unsigned         push_pct;
        int unsigned         roll;
        cap_set[5] = 5'($urandom_range(15, 2));
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_ring_traffic();
            // sender light / receiver heavy stalls, then swapped, then none
            src_idle_pct  = (ph < 2) ? 25 : (ph < 4) ? 63 : 0;
            sink_idle_pct = (ph < 2) ? 63 : (ph < 4) ? 25 : 0;
            junk = 4'($urandom_range(15));
            write_reg(REG_OVERWRITE, {junk, ow_set[ph]});
            write_reg(REG_CAPACITY, cap_set[ph]);
            push_pct = 50;
            for (int i = 0; i < WORDS_PER_PHASE; i++) begin
                if (i % 16 == 0) begin
                    roll = $urandom_range(2);
                    push_pct = (roll == 0) ? 75 : (roll == 1) ? 20 : 45;
                end
                roll = $urandom_range(99);
                if (roll < push_pct) begin
                    op = KIND_PUSH;
                end else begin
                    roll = $urandom_range(99);
                    if (roll < 35)      op = KIND_POP;
                    else if (roll < 55) op = KIND_PEEK;
                    else if (roll < 90) op = KIND_READ;
                    else if (roll < 95) op = KIND_CLEAR;
                    else op = KIND_W'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
                end
                ctype = TYPE_W'($urandom);
                cdata = $urandom;
                // half the offsets are drawn from 0 up to the stored count, the rest from 0..15
                if ($urandom_range(1) == 1) off = OFFSET_W'($urandom_range(15));
                else off = (stored > 15) ? 4'd15 : OFFSET_W'($urandom_range(stored));
                send_word(op, ctype, cdata, off);
            end
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the result path backs up and the input side has to stall.
    task automatic test_sink_stall();
        logic [KIND_W-1:0]   op;
        logic [TYPE_W-1:0]   ctype;
        logic [DATA_W-1:0]   cdata;
        drain_ring_traffic();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_reg(REG_OVERWRITE, 5'd1);
        write_reg(REG_CAPACITY, 5'd16);
        sink_hold = STALL_CYCLES;
        for (int i = 0; i < STALL_WORDS; i++) begin
            op    = (i % 3 == 2) ? KIND_READ : KIND_PUSH;
            ctype = TYPE_W'($urandom);
            cdata = $urandom;
            send_word(op, ctype, cdata, i[OFFSET_W-1:0]);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        cfg_wen       <= 1'b0;
        cfg_waddr     <= '0;
        cfg_wdata     <= '0;
        // mirror starts at the block's reset values
        ow_mode         = 1'b0;
        cap_reg         = 5'd16;
        ring_flush();
        words_sent      = 0;
        words_checked   = 0;
        hit_count       = 0;
        drop_count      = 0;
        overwrite_count = 0;
        reg_writes      = 0;
        mismatch_count  = 0;
        src_idle_pct    = 25;
        sink_idle_pct   = 63;
        sink_hold       = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_ops();
        test_capacity_limits();
        test_random_mix();
        test_sink_stall();

        drain_ring_traffic();
        repeat (8) @(posedge aclk);
        $display("covered %0d command words (%0d results checked) over %0d register writes",
                 words_sent, words_checked, reg_writes);
        $display("ring returned %0d hits, discarded %0d pushes, overwrote oldest %0d times",
                 hit_count, drop_count, overwrite_count);
        if (mismatch_count == 0 && due_results.size() == 0) begin
            $display("command_ring_fifo_tb: clean");
        end else begin
            $display("%0d mismatches, %0d results still owed", mismatch_count,
                     due_results.size());
            $display("command_ring_fifo_tb: errors");
        end
        $finish;
    end

    // hang guard: far beyond the slowest legal run
    initial begin
        #2000000;
        $display("timeout with %0d results still owed", due_results.size());
        $display("command_ring_fifo_tb: errors");
        $finish;
    end

endmodule
